>>> rtl/ppmn_pkg.sv
// Shared types, constants and character helpers for the PPM negative stream.
// No dependencies; compile first.
`default_nettype none

package ppmn_pkg;

	// Token length limit: a token closes once it holds TOKEN_CHARS-1 characters.
	localparam int TOKEN_CHARS = 64;
	// Width of the width/height/maxval fields; values saturate at 2^DIM_BITS-1.
	localparam int DIM_BITS = 16;

	localparam int LEN_W = $clog2(TOKEN_CHARS);
	localparam int ACC_W = DIM_BITS + 4;
	localparam int PIX_W = 2 * DIM_BITS;

	localparam logic [LEN_W-1:0] TOKEN_FULL = LEN_W'(TOKEN_CHARS - 1);
	localparam logic [DIM_BITS-1:0] VAL_MAX = '1;

	// Bytes per pixel, counted by a small sub-counter: 0, 1, 2.
	localparam logic [1:0] SUB_LAST = 2'd2;

	localparam logic [7:0] CH_TAB = 8'd9;
	localparam logic [7:0] CH_LF = 8'd10;
	localparam logic [7:0] CH_CR = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_HASH = 8'd35;
	localparam logic [7:0] CH_ZERO = 8'd48;
	localparam logic [7:0] CH_NINE = 8'd57;

	localparam logic [1:0] TOK_MAGIC = 2'd0;
	localparam logic [1:0] TOK_WIDTH = 2'd1;
	localparam logic [1:0] TOK_HEIGHT = 2'd2;
	localparam logic [1:0] TOK_MAXVAL = 2'd3;

	typedef enum logic [2:0] {
		PH_SKIP,
		PH_SKIP_COMMENT,
		PH_TOKEN,
		PH_TAIL_COMMENT,
		PH_RASTER
	} phase_t;

	// Header parser to raster unit.
	typedef struct packed {
		logic                in_raster;
		logic                load;
		logic                hdr_last;
		logic [DIM_BITS-1:0] width;
		logic [DIM_BITS-1:0] height;
		logic [DIM_BITS-1:0] max_value;
	} hdr_ctl_t;

	function automatic logic is_ws(input logic [7:0] c);
		is_ws = (c inside {[CH_TAB:CH_CR], CH_SPACE});
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		is_digit = (c inside {[CH_ZERO:CH_NINE]});
	endfunction

	function automatic logic is_eol(input logic [7:0] c);
		is_eol = (c inside {CH_LF, CH_CR});
	endfunction

endpackage

`default_nettype wire

>>> rtl/ppmn_byte_if.sv
// Valid/ready channel carrying one stream byte per request.
// No dependencies.
`default_nettype none

interface ppmn_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/ppmn_res_if.sv
// Valid/ready channel carrying one result byte with its header and last flags.
// No dependencies.
`default_nettype none

interface ppmn_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       in_header;
	logic       image_last;

	modport source (output valid, output out_byte, output in_header, output image_last,
		input ready);
	modport sink (input valid, input out_byte, input in_header, input image_last,
		output ready);
endinterface

`default_nettype wire

>>> rtl/ppmn_parse.sv
// Header parser: phase tracking, token accumulation, width/height/maxval capture.
// Depends on ppmn_pkg.
`default_nettype none

module ppmn_parse (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               accept,
	input  wire logic [7:0]         data_byte,
	input  wire logic               raster_last,
	output ppmn_pkg::hdr_ctl_t      ctl
);
	import ppmn_pkg::*;

	phase_t              phase_q, phase_d;
	logic [1:0]          tok_num_q, tok_num_d;
	logic [LEN_W-1:0]    tok_len_q, tok_len_d;
	logic                stopped_q, stopped_d;
	logic [DIM_BITS-1:0] tok_val_q, tok_val_d;
	logic [DIM_BITS-1:0] width_q, width_d;
	logic [DIM_BITS-1:0] height_q, height_d;
	logic [DIM_BITS-1:0] max_q, max_d;

	// Character intake, starting from a clean token while skipping.
	logic [LEN_W-1:0]    base_len, tk_len;
	logic                base_stop, tk_stop, tk_full;
	logic [DIM_BITS-1:0] base_val, tk_val;
	logic [ACC_W-1:0]    acc;

	always_comb begin
		base_len  = (phase_q == PH_SKIP) ? '0 : tok_len_q;
		base_stop = (phase_q == PH_SKIP) ? 1'b0 : stopped_q;
		base_val  = (phase_q == PH_SKIP) ? '0 : tok_val_q;
		acc = (ACC_W'(base_val) << 3) + (ACC_W'(base_val) << 1)
			+ ACC_W'(data_byte[3:0]);
		if (!base_stop && is_digit(data_byte)) begin
			tk_stop = 1'b0;
			tk_val  = (acc > ACC_W'(VAL_MAX)) ? VAL_MAX : acc[DIM_BITS-1:0];
		end else begin
			tk_stop = 1'b1;
			tk_val  = base_val;
		end
		tk_len  = base_len + LEN_W'(1);
		tk_full = (tk_len == TOKEN_FULL);
	end

	logic                do_end, end_hash, do_finish, restart, load_c, hdr_last_c;
	logic [DIM_BITS-1:0] end_val;

	always_comb begin
		phase_d    = phase_q;
		tok_num_d  = tok_num_q;
		tok_len_d  = tok_len_q;
		stopped_d  = stopped_q;
		tok_val_d  = tok_val_q;
		width_d    = width_q;
		height_d   = height_q;
		max_d      = max_q;
		do_end     = 1'b0;
		end_hash   = 1'b0;
		end_val    = tok_val_q;
		do_finish  = 1'b0;
		restart    = 1'b0;
		load_c     = 1'b0;
		hdr_last_c = 1'b0;

		case (phase_q)
			PH_SKIP: begin
				if (data_byte == CH_HASH) begin
					phase_d = PH_SKIP_COMMENT;
				end else if (!is_ws(data_byte)) begin
					tok_len_d = tk_len;
					stopped_d = tk_stop;
					tok_val_d = tk_val;
					phase_d   = PH_TOKEN;
					if (tk_full) begin
						do_end  = 1'b1;
						end_val = tk_val;
					end
				end
			end
			PH_SKIP_COMMENT: begin
				if (is_eol(data_byte))
					phase_d = PH_SKIP;
			end
			PH_TOKEN: begin
				if (data_byte == CH_HASH) begin
					do_end   = 1'b1;
					end_hash = 1'b1;
				end else if (is_ws(data_byte)) begin
					do_end = 1'b1;
				end else begin
					tok_len_d = tk_len;
					stopped_d = tk_stop;
					tok_val_d = tk_val;
					if (tk_full) begin
						do_end  = 1'b1;
						end_val = tk_val;
					end
				end
			end
			PH_TAIL_COMMENT: begin
				if (is_eol(data_byte))
					do_finish = 1'b1;
			end
			PH_RASTER: begin
				if (raster_last)
					restart = 1'b1;
			end
			default: begin
				restart = 1'b1;
			end
		endcase

		if (do_end) begin
			case (tok_num_q)
				TOK_WIDTH:  width_d  = end_val;
				TOK_HEIGHT: height_d = end_val;
				TOK_MAXVAL: max_d    = end_val;
				default:    ;
			endcase
			tok_len_d = '0;
			stopped_d = 1'b0;
			tok_val_d = '0;
			if (tok_num_q == TOK_MAXVAL) begin
				if (end_hash)
					phase_d = PH_TAIL_COMMENT;
				else
					do_finish = 1'b1;
			end else begin
				tok_num_d = tok_num_q + 2'd1;
				phase_d   = end_hash ? PH_SKIP_COMMENT : PH_SKIP;
			end
		end

		// Width and height are already registered when the header closes.
		if (do_finish) begin
			if (width_q == '0 || height_q == '0) begin
				hdr_last_c = 1'b1;
				restart    = 1'b1;
			end else begin
				phase_d = PH_RASTER;
				load_c  = 1'b1;
			end
		end

		if (restart) begin
			phase_d   = PH_SKIP;
			tok_num_d = TOK_MAGIC;
			tok_len_d = '0;
			stopped_d = 1'b0;
			tok_val_d = '0;
			width_d   = '0;
			height_d  = '0;
			max_d     = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_SKIP;
			tok_num_q <= TOK_MAGIC;
			tok_len_q <= '0;
			stopped_q <= 1'b0;
			tok_val_q <= '0;
			width_q   <= '0;
			height_q  <= '0;
			max_q     <= '0;
		end else if (accept) begin
			phase_q   <= phase_d;
			tok_num_q <= tok_num_d;
			tok_len_q <= tok_len_d;
			stopped_q <= stopped_d;
			tok_val_q <= tok_val_d;
			width_q   <= width_d;
			height_q  <= height_d;
			max_q     <= max_d;
		end
	end

	always_comb begin
		ctl.in_raster = (phase_q == PH_RASTER);
		ctl.load      = accept && load_c;
		ctl.hdr_last  = hdr_last_c;
		ctl.width     = width_q;
		ctl.height    = height_q;
		ctl.max_value = max_q;
	end

	a_load_needs_dims: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |-> (width_q != '0 && height_q != '0))
		else $error("raster load with an empty dimension");
	a_raster_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |=> phase_q == PH_RASTER)
		else $error("raster phase not entered after load");
	a_token_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_TOKEN |-> tok_len_q != '0 && tok_len_q < TOKEN_FULL)
		else $error("token length out of range");

endmodule

`default_nettype wire

>>> rtl/ppmn_raster.sv
// Raster unit: pixel/byte countdown and the maxval negation of each byte.
// Depends on ppmn_pkg.
`default_nettype none

module ppmn_raster (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               accept,
	input  wire ppmn_pkg::hdr_ctl_t ctl,
	input  wire logic [7:0]         data_byte,
	output logic [7:0]              neg_byte,
	output logic                    raster_last
);
	import ppmn_pkg::*;

	logic [PIX_W-1:0]    pix_left_q;
	logic [1:0]          sub_q;
	logic [DIM_BITS-1:0] clamped, diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_left_q <= '0;
			sub_q      <= '0;
		end else if (ctl.load) begin
			pix_left_q <= PIX_W'(ctl.width) * PIX_W'(ctl.height);
			sub_q      <= '0;
		end else if (accept && ctl.in_raster) begin
			if (sub_q == SUB_LAST) begin
				sub_q      <= '0;
				pix_left_q <= pix_left_q - PIX_W'(1);
			end else begin
				sub_q <= sub_q + 2'd1;
			end
		end
	end

	always_comb begin
		clamped     = (DIM_BITS'(data_byte) > ctl.max_value) ? ctl.max_value
			: DIM_BITS'(data_byte);
		diff        = ctl.max_value - clamped;
		neg_byte    = diff[7:0];
		raster_last = (pix_left_q == PIX_W'(1)) && (sub_q == SUB_LAST);
	end

	a_sub_range: assert property (@(posedge clk) disable iff (!arst_n)
		sub_q != 2'd3)
		else $error("byte-in-pixel counter out of range");
	a_count_live: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.in_raster |-> pix_left_q != '0)
		else $error("raster phase with no pixels left");
	a_last_empties: assert property (@(posedge clk) disable iff (!arst_n)
		accept && ctl.in_raster && raster_last |=> pix_left_q == '0 || ctl.in_raster == 1'b0)
		else $error("counter not drained after last byte");

endmodule

`default_nettype wire

>>> rtl/ppmn_res_if_unused_guard.sv
// Result register stage: holds one finished result while the next request is taken.
// Depends on ppmn_pkg and ppmn_res_if.
`default_nettype none

module ppmn_outreg (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       load,
	input  wire logic [7:0] out_byte_d,
	input  wire logic       in_header_d,
	input  wire logic       image_last_d,
	output logic            room,
	ppmn_res_if.source      result
);
	import ppmn_pkg::*;

	logic       valid_q;
	logic [7:0] out_byte_q;
	logic       in_header_q;
	logic       image_last_q;

	assign room = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (load)
			valid_q <= 1'b1;
		else if (result.ready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q   <= out_byte_d;
			in_header_q  <= in_header_d;
			image_last_q <= image_last_d;
		end
	end

	assign result.valid      = valid_q;
	assign result.out_byte   = out_byte_q;
	assign result.in_header  = in_header_q;
	assign result.image_last = image_last_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> room)
		else $error("result overwritten before it was taken");
	a_room_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_q |-> room)
		else $error("empty result stage refuses a request");
	a_raster_byte_flags: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && image_last_q && !in_header_q |-> $countones({valid_q, image_last_q}) == 2)
		else $error("last flag without a valid result");

endmodule

`default_nettype wire

>>> rtl/ppm_p6_negative_stream.sv
// Top level of the PPM P6 negative stream: header parser, raster unit, result stage.
// Depends on ppmn_pkg, ppmn_byte_if, ppmn_res_if, ppmn_parse, ppmn_raster, ppmn_outreg.
`default_nettype none

// Binary PPM (P6) negative on a byte stream. Each request on stream carries one byte
// and yields exactly one request on result. Header bytes come back unchanged with
// in_header set; while they pass, the magic, width, height and maxval tokens are parsed
// (whitespace is bytes 9..13 and space, '#' opens a comment that runs to CR or LF, a
// token closes at whitespace, at '#', or at TOKEN_CHARS-1 characters, and decimal values
// saturate at 2^DIM_BITS-1; the magic is not checked). The header closes on the byte that
// ends maxval, or on the CR/LF of a comment that directly ended it. Then width*height*3
// raster bytes come back as the low 8 bits of maxval - min(byte, maxval), with in_header
// clear. image_last marks the final byte of the image (the last header byte when width or
// height is zero), after which the block parses the next byte as a new header. Timing: one
// byte per clock unless result stalls; a byte's result is registered and shows in the next
// cycle. The single result register is refilled in the same cycle it is drained, so
// stream.ready only drops while result stalls with a result held. No reset sweep is needed:
// the block takes requests from the first clock after reset.
module ppm_p6_negative_stream (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ppmn_byte_if.sink  stream,
	ppmn_res_if.source result
);
	import ppmn_pkg::*;

	logic     room;
	logic     accept;
	hdr_ctl_t ctl;
	logic     raster_last;
	logic [7:0] neg_byte;
	logic [7:0] out_byte_d;
	logic       image_last_d;

	// Take a request whenever the result stage has room or is being drained.
	assign stream.ready = room;
	assign accept       = stream.valid && room;

	ppmn_parse u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.data_byte   (stream.data_byte),
		.raster_last (raster_last),
		.ctl         (ctl)
	);

	ppmn_raster u_raster (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.ctl         (ctl),
		.data_byte   (stream.data_byte),
		.neg_byte    (neg_byte),
		.raster_last (raster_last)
	);

	// Echo header bytes; negate raster bytes. Flag the image end from either side.
	assign out_byte_d   = ctl.in_raster ? neg_byte : stream.data_byte;
	assign image_last_d = ctl.in_raster ? raster_last : ctl.hdr_last;

	ppmn_outreg u_outreg (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (accept),
		.out_byte_d   (out_byte_d),
		.in_header_d  (!ctl.in_raster),
		.image_last_d (image_last_d),
		.room         (room),
		.result       (result)
	);

	// The last raster byte drops the block back to header parsing.
	a_restart_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		accept && ctl.in_raster && raster_last |=> !ctl.in_raster)
		else $error("raster phase kept after the last byte");
	// A raster byte that is not the last keeps the raster phase.
	a_raster_continues: assert property (@(posedge clk) disable iff (!arst_n)
		accept && ctl.in_raster && !raster_last |=> ctl.in_raster)
		else $error("raster phase left early");
	// A request leaves its flags in the result stage in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> result.valid && result.in_header == !$past(ctl.in_raster))
		else $error("result does not follow its request");

endmodule

`default_nettype wire

>>> sim/ppm_p6_negative_stream_test.sv
// Self-checking testbench for ppm_p6_negative_stream: directed P6 headers, then random images.
// Depends on ppmn_pkg, ppmn_byte_if, ppmn_res_if and the ppm_p6_negative_stream RTL.
`timescale 1ns / 1ps

module ppm_p6_negative_stream_test;
	import ppmn_pkg::*;

	// Stop the run here no matter what; the slowest legal run is far shorter.
	localparam int unsigned CYCLE_LIMIT = 200_000;
	// Length of the one long receiver hold-off.
	localparam int unsigned HOLD_CYCLES = 150;
	// Random bytes to offer after the directed tests.
	localparam int unsigned RANDOM_BYTES = 240;

	// One result byte as the block sends it.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       in_header;
		logic       image_last;
	} out_rec_t;

	logic clk;
	logic arst_n;

	ppmn_byte_if stream_ch ();
	ppmn_res_if  result_ch ();

	ppm_p6_negative_stream u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_ch),
		.result (result_ch)
	);

	// Bytes the block still owes us, oldest first.
	out_rec_t    owed_bytes[$];
	int unsigned mismatches = 0;
	int unsigned bytes_sent = 0;
	int unsigned cycle_count = 0;
	int unsigned burst_left = 0;
	bit          hold_off_req = 1'b0;

	// Parser image of the block: header phase, current token and image geometry.
	phase_t                  hdr_phase = PH_SKIP;
	logic [1:0]              tok_idx = TOK_MAGIC;
	int unsigned             tok_len = 0;
	bit                      tok_nondigit = 1'b0;
	int unsigned             tok_value = 0;
	logic [DIM_BITS-1:0]     img_width = '0;
	logic [DIM_BITS-1:0]     img_height = '0;
	logic [DIM_BITS-1:0]     img_maxval = '0;
	longint unsigned         raster_left = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Header parser and raster negation, one byte at a time
	// ------------------------------------------------------------------

	// Whitespace per the P6 grammar: TAB through CR, and space.
	function automatic bit blank(input logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic bit line_end(input logic [7:0] c);
		return c == CH_LF || c == CH_CR;
	endfunction

	// Drop everything back to the start of a new header.
	function automatic void restart_image();
		hdr_phase = PH_SKIP;
		tok_idx = TOK_MAGIC;
		tok_len = 0;
		tok_nondigit = 1'b0;
		tok_value = 0;
		img_width = '0;
		img_height = '0;
		img_maxval = '0;
		raster_left = 0;
	endfunction

	// Fold one token character into the value; digits stop at the first non-digit.
	function automatic void absorb_char(input logic [7:0] c);
		int unsigned nxt;
		if (!tok_nondigit && c >= CH_ZERO && c <= CH_NINE) begin
			nxt = tok_value * 10 + (c - CH_ZERO);
			tok_value = (nxt > VAL_MAX) ? VAL_MAX : nxt;
		end else begin
			tok_nondigit = 1'b1;
		end
		tok_len++;
	endfunction

	// Size the raster; an empty one ends the image right here.
	function automatic bit open_raster();
		raster_left = 64'(img_width) * 64'(img_height) * 64'(3);
		if (raster_left == 0)
			return 1'b1;
		hdr_phase = PH_RASTER;
		return 1'b0;
	endfunction

	// Store the token that just closed and move to the next one.
	function automatic bit close_token(input bit by_hash);
		case (tok_idx)
			TOK_WIDTH: img_width = tok_value[DIM_BITS-1:0];
			TOK_HEIGHT: img_height = tok_value[DIM_BITS-1:0];
			TOK_MAXVAL: img_maxval = tok_value[DIM_BITS-1:0];
			default: ;
		endcase
		tok_len = 0;
		tok_nondigit = 1'b0;
		tok_value = 0;
		if (tok_idx == TOK_MAXVAL) begin
			if (by_hash) begin
				hdr_phase = PH_TAIL_COMMENT;
				return 1'b0;
			end
			return open_raster();
		end
		tok_idx++;
		if (by_hash)
			hdr_phase = PH_SKIP_COMMENT;
		else
			hdr_phase = PH_SKIP;
		return 1'b0;
	endfunction

	// Result byte for one accepted request byte; advances the parser image.
	function automatic out_rec_t negate_next(input logic [7:0] c);
		out_rec_t            rec;
		bit                  last;
		logic [DIM_BITS-1:0] clipped;
		logic [DIM_BITS-1:0] diff;
		rec.out_byte = c;
		rec.in_header = 1'b1;
		last = 1'b0;
		case (hdr_phase)
			PH_SKIP: begin
				if (c == CH_HASH) begin
					hdr_phase = PH_SKIP_COMMENT;
				end else if (!blank(c)) begin
					tok_len = 0;
					tok_nondigit = 1'b0;
					tok_value = 0;
					absorb_char(c);
					hdr_phase = PH_TOKEN;
					if (tok_len >= TOKEN_CHARS - 1)
						last = close_token(1'b0);
				end
			end
			PH_SKIP_COMMENT: begin
				if (line_end(c))
					hdr_phase = PH_SKIP;
			end
			PH_TOKEN: begin
				if (c == CH_HASH) begin
					last = close_token(1'b1);
				end else if (blank(c)) begin
					last = close_token(1'b0);
				end else begin
					absorb_char(c);
					if (tok_len >= TOKEN_CHARS - 1)
						last = close_token(1'b0);
				end
			end
			PH_TAIL_COMMENT: begin
				if (line_end(c))
					last = open_raster();
			end
			default: begin
				// Clamp to maxval, negate, keep the low byte.
				clipped = (DIM_BITS'(c) > img_maxval) ? img_maxval : DIM_BITS'(c);
				diff = img_maxval - clipped;
				rec.out_byte = diff[7:0];
				rec.in_header = 1'b0;
				if (raster_left > 0)
					raster_left--;
				if (raster_left == 0)
					last = 1'b1;
			end
		endcase
		rec.image_last = last;
		if (last)
			restart_image();
		return rec;
	endfunction

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------

	// Offer one byte; bursts of random length are separated by random gaps.
	// Called and returns at a rising edge; valid is left high for the next byte.
	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(40, 1);
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
			if (gap != 0) begin
				stream_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		stream_ch.valid <= 1'b1;
		stream_ch.data_byte <= b;
		@(posedge clk);
		while (stream_ch.ready !== 1'b1)
			@(posedge clk);
		owed_bytes.push_back(negate_next(b));
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// Send the low n bytes of v, most significant byte first.
	task automatic send_bytes(input int n, input logic [8*16-1:0] v);
		for (int i = 0; i < n; i++)
			send_byte(v[8*(n-1-i) +: 8]);
	endtask

	// Pause the sender until every owed byte is back, then let the block settle.
	task automatic settle_out();
		stream_ch.valid <= 1'b0;
		while (owed_bytes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Random header pieces
	// ------------------------------------------------------------------

	function automatic logic [7:0] ws_char();
		int unsigned r;
		r = $urandom_range(5);
		return (r == 5) ? CH_SPACE : CH_TAB + 8'(r);
	endfunction

	// '#', random body of any byte but CR/LF, then CR or LF.
	task automatic send_comment();
		logic [7:0] b;
		send_byte(CH_HASH);
		repeat ($urandom_range(6)) begin
			do
				b = 8'($urandom_range(255));
			while (line_end(b));
			send_byte(b);
		end
		send_byte($urandom_range(1) ? CH_LF : CH_CR);
	endtask

	// Token separator: whitespace run, or a comment that closes the token directly,
	// sometimes followed by a comment while skipping.
	task automatic send_separator();
		if ($urandom_range(4) == 0)
			send_comment();
		else
			repeat ($urandom_range(3, 1)) send_byte(ws_char());
		if ($urandom_range(5) == 0)
			send_comment();
	endtask

	// Decimal token with optional leading zeros, trailing junk, or padding to full length.
	task automatic send_number(input int unsigned v, input bit pad);
		string s;
		s = $sformatf("%0d", v);
		if ($urandom_range(4) == 0)
			s = {"00", s};
		if ($urandom_range(5) == 0)
			s = {s, "k"};
		if (pad)
			while (s.len() < TOKEN_CHARS - 1)
				s = {"0", s};
		send_text(s);
	endtask

	// One well-formed image with random content; the raster length follows the parser.
	task automatic send_random_image();
		int unsigned w;
		int unsigned h;
		int unsigned m;
		logic [7:0]  b;
		if ($urandom_range(3) == 0)
			send_separator();
		if ($urandom_range(3) != 0) begin
			send_text("P6");
		end else begin
			repeat ($urandom_range(4, 1)) begin
				do
					b = 8'($urandom_range(255));
				while (blank(b) || b == CH_HASH);
				send_byte(b);
			end
		end
		send_separator();
		// Mostly tiny images; now and then a huge width with no rows.
		if ($urandom_range(9) == 0) begin
			w = $urandom_range(1) ? 99999 : $urandom_range(65535);
			h = 0;
		end else begin
			w = $urandom_range(4);
			h = $urandom_range(4);
		end
		send_number(w, $urandom_range(7) == 0);
		send_separator();
		send_number(h, 1'b0);
		send_separator();
		case ($urandom_range(5))
			0: m = 255;
			1: m = $urandom_range(255);
			2: m = $urandom_range(1);
			3: m = $urandom_range(65535, 256);
			4: m = 99999;
			default: m = $urandom_range(15, 1);
		endcase
		send_number(m, 1'b0);
		// maxval closes on one whitespace byte, or on a comment through its line end.
		if ($urandom_range(2) == 0)
			send_comment();
		else
			send_byte(ws_char());
		while (hdr_phase == PH_RASTER) begin
			case ($urandom_range(7))
				0: send_byte(8'h00);
				1: send_byte(8'hFF);
				default: send_byte(8'($urandom_range(255)));
			endcase
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Plain header with newlines, 2x1 raster at maxval 255.
	task automatic test_plain_image();
		send_text("P6\n2 1\n255\n");
		send_bytes(6, {8'd0, 8'd255, 8'd1, 8'd254, 8'd128, 8'd127});
		settle_out();
	endtask

	// Comments while skipping, tokens closed by '#', every whitespace byte, and a
	// maxval closed by '#' so the header ends on the comment's LF.
	task automatic test_comments();
		send_text("#c\015P6\011# x\n3\0131#w\n \0147#m\n");
		send_bytes(9, {8'd0, 8'd7, 8'd8, 8'd255, 8'd3, 8'd6, 8'd200, 8'd1, 8'd4});
		settle_out();
	endtask

	// Zero width, zero height with a saturated width: the image ends on the header.
	task automatic test_empty_raster();
		send_text("P6 0 5 255 ");
		send_text("P6 99999 0 1\n");
		settle_out();
	endtask

	// Tokens that close on length alone: the next byte starts the next token.
	task automatic test_long_token();
		string s;
		s = "";
		while (s.len() < TOKEN_CHARS - 1)
			s = {s, "M"};
		send_text(s);
		send_text("1 1 9 ");
		send_bytes(3, {8'd0, 8'd9, 8'd10});
		s = "1";
		while (s.len() < TOKEN_CHARS - 1)
			s = {"0", s};
		send_text({"P6 ", s, "2 3 "});
		send_bytes(6, {8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd255});
		settle_out();
	endtask

	// maxval above 255, saturated maxval, and maxval zero.
	task automatic test_wide_maxval();
		send_text("P6 1 1 300\n");
		send_bytes(3, {8'd0, 8'd255, 8'd44});
		send_text("P6 1 1 70000 ");
		send_bytes(3, {8'd0, 8'd255, 8'd17});
		send_text("P6 1 1 0\n");
		send_bytes(3, {8'd0, 8'd255, 8'd77});
		settle_out();
	endtask

	// Unchecked magic with bytes 00 and FF, tokens with trailing junk or no digits,
	// and a maxval comment closed by CR.
	task automatic test_odd_tokens();
		send_bytes(2, {8'h00, 8'hFF});
		send_text(" 2ab\0111 x1 ");
		send_bytes(6, {8'd255, 8'd0, 8'd1, 8'd2, 8'd128, 8'd9});
		send_text("Q9 2 x 5#\015");
		send_text("P6 1 1 255#\015");
		send_bytes(3, {8'd5, 8'd250, 8'd0});
		settle_out();
	endtask

	// Hold the receiver off for a long stretch while the sender keeps offering,
	// so the result register fills and the block stalls its input.
	task automatic test_backpressure();
		hold_off_req = 1'b1;
		send_text("P6 4 3 255\n");
		repeat (36) send_byte(8'($urandom_range(255)));
		settle_out();
	endtask

	task automatic test_random_images();
		int unsigned start;
		start = bytes_sent;
		while (bytes_sent - start < RANDOM_BYTES)
			send_random_image();
		settle_out();
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n <= 1'b0;
		stream_ch.valid <= 1'b0;
		stream_ch.data_byte <= '0;
		restart_image();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_plain_image();
		test_comments();
		test_empty_raster();
		test_long_token();
		test_wide_maxval();
		test_odd_tokens();
		test_backpressure();
		test_random_images();

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Receiver: stretches of random stall density, including stretches with none,
	// plus the one long hold-off on request.
	initial begin : receiver
		int unsigned stall_pct;
		int unsigned stretch;
		stall_pct = 0;
		stretch = 0;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (stretch == 0) begin
				stretch = $urandom_range(60, 8);
				case ($urandom_range(3))
					0: stall_pct = 0;
					1: stall_pct = 25;
					2: stall_pct = 60;
					default: stall_pct = 90;
				endcase
			end
			stretch--;
			result_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Compare one field of a result byte against the owed value.
	function automatic void check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %02h, actual %02h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Check every result request against the oldest owed byte.
	always @(posedge clk) begin : result_check
		out_rec_t want;
		if (arst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (owed_bytes.size() == 0) begin
				$display("%0t: result expected none, actual %02h", $time,
					result_ch.out_byte);
				mismatches++;
			end else begin
				want = owed_bytes.pop_front();
				check_field("out_byte", want.out_byte, result_ch.out_byte);
				check_field("in_header", 8'(want.in_header), 8'(result_ch.in_header));
				check_field("image_last", 8'(want.image_last), 8'(result_ch.image_last));
			end
		end
	end

	// Watchdog: end a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d bytes still owed", cycle_count,
				owed_bytes.size());
			$display("Mismatches found");
			$finish;
		end
	end

endmodule

>>> ppm_p6_negative_stream.f
rtl/ppmn_pkg.sv
rtl/ppmn_byte_if.sv
rtl/ppmn_res_if.sv
rtl/ppmn_parse.sv
rtl/ppmn_raster.sv
rtl/ppmn_res_if_unused_guard.sv
rtl/ppm_p6_negative_stream.sv
sim/ppm_p6_negative_stream_test.sv
